// ===== rtl/ppe_pkg.sv =====
// Package for the perfect power exponent core.
// Holds widths, search limits and payload types; no dependencies.
`default_nettype none

package ppe_pkg;

    localparam int MAX_EXPONENT = 31;
    localparam int VALUE_W      = 32;
    localparam int EXP_W        = 5;
    localparam int MAG_W        = VALUE_W + 1;
    localparam int ROOT_W       = VALUE_W / 2 + 2;
    localparam int MUL_W        = MAG_W + ROOT_W;
    localparam int CNT_W        = $clog2(MAX_EXPONENT + 1);

    localparam logic [MAG_W-1:0]  POW_CAP = MAG_W'(1) << VALUE_W;
    localparam logic [ROOT_W-1:0] ROOT_LO = ROOT_W'(1);
    localparam logic [ROOT_W-1:0] ROOT_HI = ROOT_W'(1) << (VALUE_W / 2);

    localparam logic [CNT_W-1:0] P_START_POS = CNT_W'(MAX_EXPONENT);
    localparam logic [CNT_W-1:0] P_START_NEG =
        CNT_W'(MAX_EXPONENT - ((MAX_EXPONENT % 2 == 0) ? 1 : 0));

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [EXP_W-1:0]          exponent_t;

endpackage

`default_nettype wire

// ===== rtl/ppe_in_if.sv =====
// Input channel of the perfect power exponent core: valid, ready, value.
// Depends on ppe_pkg.
`default_nettype none

interface ppe_in_if;
    logic            valid;
    logic            ready;
    ppe_pkg::value_t value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/ppe_out_if.sv =====
// Result channel of the perfect power exponent core: valid, ready, exponent.
// Depends on ppe_pkg.
`default_nettype none

interface ppe_out_if;
    logic               valid;
    logic               ready;
    ppe_pkg::exponent_t exponent;

    modport source (output valid, output exponent, input ready);
    modport sink (input valid, input exponent, output ready);
endinterface

`default_nettype wire

// ===== rtl/perfect_power_exponent_core.sv =====
// Perfect power exponent core: largest p with value an exact p-th power.
// Depends on ppe_pkg, ppe_in_if and ppe_out_if.
// 0, 1 and -1 go straight to the result; otherwise exponents run from high to low,
// each with up to 17 binary-search steps of a midpoint, k multiply and a compare
// state, k being the multiplications until the power matches its count or
// saturates. One transaction at a time: item.ready is high only while idle.
// Throughput is set by the single 33x18 multiplier.
// Reset (rst_n low, asynchronous) returns to idle with no result pending.
`default_nettype none

module perfect_power_exponent_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ppe_in_if.sink     item,
    ppe_out_if.source  result
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MID  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_CMP  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic                            out_valid_reg, out_valid_next;
    logic [ppe_pkg::CNT_W-1:0]       p_reg, p_next;
    logic [ppe_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            neg_reg, neg_next;
    logic [ppe_pkg::MAG_W-1:0]       mag_reg, mag_next;
    logic [ppe_pkg::ROOT_W-1:0]      lo_reg, lo_next;
    logic [ppe_pkg::ROOT_W-1:0]      hi_reg, hi_next;
    logic [ppe_pkg::ROOT_W-1:0]      mid_reg, mid_next;
    logic [ppe_pkg::MAG_W-1:0]       acc_reg, acc_next;
    ppe_pkg::exponent_t              res_reg, res_next;
    ppe_pkg::exponent_t              exponent_reg, exponent_next;

    logic                            in_neg;
    logic [ppe_pkg::MAG_W-1:0]       in_mag;
    logic [ppe_pkg::MUL_W-1:0]       prod;
    logic                            prod_sat;
    logic [ppe_pkg::CNT_W-1:0]       cnt_inc;
    logic [ppe_pkg::ROOT_W:0]        mid_sum;
    logic [ppe_pkg::ROOT_W-1:0]      lo_upd, hi_upd;
    logic [ppe_pkg::CNT_W-1:0]       p_dec;

    assign item.ready      = (state_reg == ST_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.exponent = exponent_reg;

    assign in_neg   = item.value[ppe_pkg::VALUE_W-1];
    assign in_mag   = in_neg ? (ppe_pkg::POW_CAP - {1'b0, item.value})
                             : {1'b0, item.value};
    assign prod     = ppe_pkg::MUL_W'(acc_reg) * ppe_pkg::MUL_W'(mid_reg);
    assign prod_sat = (prod >= ppe_pkg::MUL_W'(ppe_pkg::POW_CAP));
    assign cnt_inc  = cnt_reg + ppe_pkg::CNT_W'(1);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign lo_upd   = (acc_reg < mag_reg) ? (mid_reg + ppe_pkg::ROOT_W'(1)) : lo_reg;
    assign hi_upd   = (acc_reg < mag_reg) ? hi_reg : (mid_reg - ppe_pkg::ROOT_W'(1));
    assign p_dec    = neg_reg ? (p_reg - ppe_pkg::CNT_W'(2)) : (p_reg - ppe_pkg::CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        exponent_next  = exponent_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    neg_next = in_neg;
                    mag_next = in_mag;
                    lo_next  = ppe_pkg::ROOT_LO;
                    hi_next  = ppe_pkg::ROOT_HI;
                    p_next   = in_neg ? ppe_pkg::P_START_NEG : ppe_pkg::P_START_POS;
                    if (in_mag == '0 || (in_mag == ppe_pkg::MAG_W'(1) && !in_neg))
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else if (in_mag == ppe_pkg::MAG_W'(1))
                    begin
                        res_next   = ppe_pkg::EXP_W'(1);
                        state_next = ST_DONE;
                    end
                    else if ((in_neg ? ppe_pkg::P_START_NEG : ppe_pkg::P_START_POS)
                             <= ppe_pkg::CNT_W'(1))
                    begin
                        res_next   = ppe_pkg::EXP_W'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MID;
                    end
                end
            end
            ST_MID:
            begin
                mid_next   = mid_sum[ppe_pkg::ROOT_W:1];
                acc_next   = ppe_pkg::MAG_W'(1);
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next = prod_sat ? ppe_pkg::POW_CAP : prod[ppe_pkg::MAG_W-1:0];
                cnt_next = cnt_inc;
                if (prod_sat || cnt_inc == p_reg)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (acc_reg == mag_reg)
                begin
                    res_next   = ppe_pkg::EXP_W'(p_reg);
                    state_next = ST_DONE;
                end
                else if (lo_upd <= hi_upd)
                begin
                    lo_next    = lo_upd;
                    hi_next    = hi_upd;
                    state_next = ST_MID;
                end
                else if (p_dec <= ppe_pkg::CNT_W'(1))
                begin
                    res_next   = ppe_pkg::EXP_W'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    p_next     = p_dec;
                    lo_next    = ppe_pkg::ROOT_LO;
                    hi_next    = ppe_pkg::ROOT_HI;
                    state_next = ST_MID;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    exponent_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold datapath values; no reset needed
    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        exponent_reg <= exponent_next;
    end

endmodule

`default_nettype wire
